FILE: rtl/core/eta_pkg.sv
package eta_pkg;

  localparam int unsigned LowBitsDefault  = 16;
  localparam int unsigned WrapBitsDefault = 32;

  localparam int unsigned FuncWidth   = 2;
  localparam int unsigned TimeWidth   = 64;
  localparam int unsigned CountWidth  = 48;
  localparam int unsigned LeadWidth   = 16;
  localparam int unsigned ApbData     = 32;
  localparam int unsigned ApbAddr     = 3;

  localparam logic [LeadWidth-1:0] MinLeadReset = 16'd10;

  typedef enum logic [FuncWidth-1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_CANCEL = 2'd2
  } eta_func_e;

  typedef enum logic [0:0] {
    REG_MIN_LEAD = 1'b0
  } eta_reg_e;

endpackage

FILE: rtl/core/eta_if.sv
interface eta_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] alarm_value;

  modport source (output valid, func, alarm_value, input ready);
  modport sink (input valid, func, alarm_value, output ready);
endinterface

interface eta_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] count;
  logic        fire;
  logic        armed;

  modport source (output valid, count, fire, armed, input ready);
  modport sink (input valid, count, fire, armed, output ready);
endinterface

FILE: rtl/core/extended_timer_alarm_top.sv
// Channel   Dir  Payload                         Transfer
// in_i      in   func[1:0], alarm_value[63:0]    valid & ready
// out_o     out  count[47:0], fire, armed        valid & ready
// apb       in   min_lead at byte address 0      psel & penable & pwrite
//
// One item per cycle; the result is registered and shows the cycle after the transfer.
// Throughput is set by the single output register: in_i.ready drops only while
// a result waits and out_o.ready is low.
// Reset clears the counters and the compare, sets the target to all ones and min_lead to 10.
// Configuration writes are taken in any cycle and need no idle time.
module extended_timer_alarm_top
  import eta_pkg::*;
#(
  parameter int unsigned LOW_BITS  = LowBitsDefault,
  parameter int unsigned WRAP_BITS = WrapBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  eta_in_if.sink              in_i,
  eta_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddr-1:0]  paddr,
  input  logic [ApbData-1:0]  pwdata,
  output logic [ApbData-1:0]  prdata,
  output logic                pready
);

  logic [LeadWidth-1:0]  min_lead_q;
  logic [LOW_BITS-1:0]   low_q, low_d;
  logic [WRAP_BITS-1:0]  wrap_q, wrap_d;
  logic [WRAP_BITS-1:0]  wrap_inc_q, wrap_inc_d;
  logic [TimeWidth-1:0]  target_q, target_d;
  logic [LOW_BITS-1:0]   cmp_q, cmp_d;
  logic                  armed_q, armed_d;

  logic                  out_valid_q;
  logic [CountWidth-1:0] out_count_q, out_count_d;
  logic                  out_fire_q, out_fire_d;
  logic                  out_armed_q;

  logic                  in_acc;
  logic                  cfg_wr;
  logic [LOW_BITS-1:0]   low_inc;
  logic                  wraps;
  logic                  hit;
  logic [TimeWidth-1:0]  chk_now;
  logic [TimeWidth-1:0]  chk_target;
  logic                  chk_armed;
  logic [LOW_BITS-1:0]   chk_cmp;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_MIN_LEAD);
  assign prdata  = (paddr[2] == REG_MIN_LEAD) ? ApbData'(min_lead_q) : '0;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign low_inc = low_q + 1'b1;
  assign wraps   = low_inc == '0;
  assign hit     = armed_q && (low_inc == cmp_q);

  always_comb begin
    if (in_i.func == FUNC_SET) begin
      chk_now    = TimeWidth'({wrap_q, low_q});
      chk_target = in_i.alarm_value;
    end else begin
      chk_now    = TimeWidth'({wrap_inc_q, {LOW_BITS{1'b0}}});
      chk_target = target_q;
    end
  end

  eta_arm #(
    .LOW_BITS (LOW_BITS)
  ) u_arm (
    .now_i      (chk_now),
    .target_i   (chk_target),
    .min_lead_i (min_lead_q),
    .armed_o    (chk_armed),
    .cmp_low_o  (chk_cmp)
  );

  always_comb begin
    low_d      = low_q;
    wrap_d     = wrap_q;
    wrap_inc_d = wrap_inc_q;
    target_d   = target_q;
    cmp_d      = cmp_q;
    armed_d    = armed_q;
    out_fire_d = 1'b0;
    case (in_i.func)
      FUNC_TICK: begin
        low_d      = low_inc;
        out_fire_d = hit;
        armed_d    = armed_q && !hit;
        if (wraps) begin
          wrap_d     = wrap_inc_q;
          wrap_inc_d = wrap_inc_q + 1'b1;
          if (!armed_q) begin
            armed_d = chk_armed;
            cmp_d   = chk_cmp;
          end
        end
      end
      FUNC_SET: begin
        target_d = in_i.alarm_value;
        armed_d  = chk_armed;
        cmp_d    = chk_cmp;
      end
      FUNC_CANCEL: begin
        armed_d = 1'b0;
      end
      default: begin
      end
    endcase
    out_count_d = CountWidth'({wrap_d, low_d});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lead_q <= MinLeadReset;
    end else if (cfg_wr) begin
      min_lead_q <= pwdata[LeadWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= '0;
      wrap_q     <= '0;
      wrap_inc_q <= WRAP_BITS'(1);
      target_q   <= '1;
      cmp_q      <= '0;
      armed_q    <= 1'b0;
    end else if (in_acc) begin
      low_q      <= low_d;
      wrap_q     <= wrap_d;
      wrap_inc_q <= wrap_inc_d;
      target_q   <= target_d;
      cmp_q      <= cmp_d;
      armed_q    <= armed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_count_q <= out_count_d;
      out_fire_q  <= out_fire_d;
      out_armed_q <= armed_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.count = out_count_q;
  assign out_o.fire  = out_fire_q;
  assign out_o.armed = out_armed_q;

  a_inc_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrap_inc_q == WRAP_BITS'(wrap_q + 1'b1))
    else $error("wrap increment register out of step");

  a_fire_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_fire_q |-> !out_armed_q)
    else $error("compare still armed after fire");

  a_no_fire_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func != FUNC_TICK) |=> !out_fire_q)
    else $error("fire on a non-tick item");

  a_tick_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func == FUNC_TICK) |=> low_q == LOW_BITS'($past(low_q) + 1'b1))
    else $error("low counter did not advance on tick");

  a_hold_off_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.func != FUNC_TICK) |=> $stable(low_q) && $stable(wrap_q))
    else $error("counter moved on a non-tick item");

endmodule

FILE: rtl/core/eta_arm.sv
module eta_arm
  import eta_pkg::*;
#(
  parameter int unsigned LOW_BITS = LowBitsDefault
) (
  input  logic [TimeWidth-1:0] now_i,
  input  logic [TimeWidth-1:0] target_i,
  input  logic [LeadWidth-1:0] min_lead_i,
  output logic                 armed_o,
  output logic [LOW_BITS-1:0]  cmp_low_o
);

  logic [TimeWidth-1:0] earliest;
  logic [TimeWidth-1:0] ahead;
  logic [TimeWidth-1:0] lead;
  logic                 late;

  assign lead     = TimeWidth'(min_lead_i);
  assign earliest = now_i + lead;
  assign ahead    = target_i - now_i;
  assign late     = target_i >= earliest;

  always_comb begin
    if (late) begin
      armed_o   = (ahead >> LOW_BITS) == '0;
      cmp_low_o = target_i[LOW_BITS-1:0];
    end else begin
      armed_o   = (lead >> LOW_BITS) == '0;
      cmp_low_o = earliest[LOW_BITS-1:0];
    end
  end

endmodule

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eta_pkg::*;

  localparam logic [FuncWidth-1:0] FuncSpare = 2'd3;
  localparam logic [TimeWidth-1:0] LowReach = (64'd1 << LowBitsDefault) - 64'd1;
  localparam int unsigned HoldAfter   = 400;
  localparam int unsigned HoldCycles  = 150;
  localparam int unsigned TailCycles  = 5;
  localparam int unsigned ShownErrors = 40;

  typedef struct packed {
    logic [FuncWidth-1:0] func;
    logic [TimeWidth-1:0] alarm_value;
  } timer_op_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  fire;
    logic                  armed;
  } timer_view_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ApbAddr-1:0] paddr;
  logic [ApbData-1:0] pwdata;
  logic [ApbData-1:0] prdata;
  logic               pready;

  eta_in_if  in_bus ();
  eta_out_if out_bus ();

  extended_timer_alarm_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timer state as the block should hold it
  logic [LowBitsDefault-1:0]  low_q     = '0;
  logic [WrapBitsDefault-1:0] wrap_q    = '0;
  logic [TimeWidth-1:0]       target_q  = '1;
  logic [LowBitsDefault-1:0]  cmp_low_q = '0;
  logic                       cmp_on_q  = 1'b0;
  logic [LeadWidth-1:0]       lead_q    = MinLeadReset;

  timer_op_t   pending_ops[$];
  timer_view_t expected_views[$];
  timer_op_t   on_bus;

  logic [TimeWidth-1:0] plan_now = '0;
  int unsigned ops_queued   = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned fires_seen   = 0;
  int unsigned sets_done    = 0;
  int unsigned cancels_done = 0;
  int unsigned wraps_done   = 0;
  int unsigned leads_used   = 0;

  int unsigned burst_lo = 1;
  int unsigned burst_hi = 8;
  int unsigned gap_hi   = 4;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  int unsigned hold_left;
  logic        hold_done;
  logic [15:0] stall_pat;
  logic [5:0]  stall_window;

  task automatic flag_mismatch(input string what);
    errors++;
    if (errors <= ShownErrors) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic [TimeWidth-1:0] time_now();
    return (TimeWidth'(wrap_q) << LowBitsDefault) | TimeWidth'(low_q);
  endfunction

  task automatic rearm_compare();
    logic [TimeWidth-1:0] now;
    logic [TimeWidth-1:0] earliest;
    logic [TimeWidth-1:0] goal;
    now      = time_now();
    earliest = now + TimeWidth'(lead_q);
    goal     = target_q;
    cmp_on_q = 1'b0;
    if (goal < earliest) goal = earliest;
    if (goal - now <= LowReach) begin
      cmp_low_q = goal[LowBitsDefault-1:0];
      cmp_on_q  = 1'b1;
    end
  endtask

  task automatic advance_timer(input timer_op_t op, output timer_view_t view);
    logic                 was_on;
    logic                 fired;
    logic [TimeWidth-1:0] now;
    fired = 1'b0;
    case (op.func)
      FUNC_TICK: begin
        was_on = cmp_on_q;
        low_q  = low_q + 1'b1;
        if (was_on && low_q == cmp_low_q) begin
          fired    = 1'b1;
          cmp_on_q = 1'b0;
        end
        if (low_q == '0) begin
          wrap_q = wrap_q + 1'b1;
          wraps_done++;
          if (!was_on) rearm_compare();
        end
      end
      FUNC_SET: begin
        target_q = op.alarm_value;
        rearm_compare();
        sets_done++;
      end
      FUNC_CANCEL: begin
        cmp_on_q = 1'b0;
        cancels_done++;
      end
      default: ;
    endcase
    now        = time_now();
    view.count = now[CountWidth-1:0];
    view.fire  = fired;
    view.armed = cmp_on_q;
  endtask

  // sender: bursts of random length, random gaps, hold while stalled
  always @(posedge clk_i) begin : feed
    timer_op_t   nxt;
    timer_view_t want;
    if (!rst_ni) begin
      in_bus.valid       <= 1'b0;
      in_bus.func        <= FUNC_TICK;
      in_bus.alarm_value <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        advance_timer(on_bus, want);
        expected_views.push_back(want);
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_bus.valid <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          nxt = pending_ops.pop_front();
          on_bus = nxt;
          in_bus.func        <= nxt.func;
          in_bus.alarm_value <= nxt.alarm_value;
          in_bus.valid       <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(burst_lo, burst_hi);
            gap_left   = $urandom_range(0, gap_hi);
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : long_hold
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HoldAfter) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : sink_pace
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_pat     <= 16'hFFFF;
      stall_window  <= '0;
    end else begin
      stall_window <= stall_window + 1'b1;
      if (stall_window == '0) begin
        if ($urandom_range(0, 3) == 0) stall_pat <= 16'hFFFF;
        else stall_pat <= 16'($urandom) | 16'h5555;
      end else begin
        stall_pat <= {stall_pat[0], stall_pat[15:1]};
      end
      out_bus.ready <= stall_pat[0] && hold_left == 0;
    end
  end

  always @(posedge clk_i) begin : observe
    timer_view_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (out_bus.fire === 1'b1) fires_seen++;
      if (expected_views.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = expected_views.pop_front();
        if (out_bus.count !== want.count)
          flag_mismatch($sformatf("count %0h, want %0h", out_bus.count, want.count));
        if (out_bus.fire !== want.fire)
          flag_mismatch($sformatf("fire %b, want %b at count %0h",
                                  out_bus.fire, want.fire, want.count));
        if (out_bus.armed !== want.armed)
          flag_mismatch($sformatf("armed %b, want %b at count %0h",
                                  out_bus.armed, want.armed, want.count));
      end
    end
  end

  task automatic queue_op(input logic [FuncWidth-1:0] fn, input logic [TimeWidth-1:0] value);
    timer_op_t op;
    op.func        = fn;
    op.alarm_value = value;
    pending_ops.push_back(op);
    ops_queued++;
    if (fn == FUNC_TICK) plan_now = plan_now + 1'b1;
  endtask

  function automatic logic [TimeWidth-1:0] pick_target();
    case ($urandom_range(0, 6))
      0, 1: return plan_now + $urandom_range(0, 250);
      2: return plan_now - $urandom_range(0, 120);
      3: return plan_now + $urandom_range(65400, 65700);
      4: return {$urandom, $urandom};
      5: return 64'd1 << $urandom_range(0, 63);
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  task automatic queue_random(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) queue_op(FUNC_TICK, {$urandom, $urandom});
      else if (pick < 82) queue_op(FUNC_SET, pick_target());
      else if (pick < 92) queue_op(FUNC_CANCEL, {$urandom, $urandom});
      else queue_op(FuncSpare, {$urandom, $urandom});
    end
  endtask

  task automatic pace_sender(input int unsigned lo, input int unsigned hi, input int unsigned gap);
    burst_lo = lo;
    burst_hi = hi;
    gap_hi   = gap;
  endtask

  task automatic wait_settled();
    while (results_seen != ops_queued) @(posedge clk_i);
  endtask

  task automatic write_min_lead(input logic [LeadWidth-1:0] value);
    wait_settled();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddr'(4 * REG_MIN_LEAD);
    pwdata  <= ApbData'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lead_q = value;
    leads_used++;
  endtask

  initial begin : stimulus
    logic [LeadWidth-1:0] lead_plan [5];
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    rst_ni  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    pace_sender(1, 6, 3);
    queue_op(FUNC_TICK, '0);
    queue_op(FuncSpare, '1);
    queue_op(FUNC_CANCEL, 64'h5555_5555_5555_5555);
    queue_op(FUNC_SET, '0);
    repeat (11) queue_op(FUNC_TICK, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_op(FUNC_SET, '1);
    queue_op(FUNC_SET, plan_now + 64'd65546);
    queue_op(FUNC_SET, plan_now + 64'd65535);
    queue_op(FUNC_CANCEL, '0);
    queue_op(FUNC_SET, plan_now + 64'd5);
    repeat (3) queue_op(FUNC_TICK, '1);
    wait_settled();

    lead_plan = '{16'd0, 16'hFFFF, 16'd1, 16'($urandom), 16'd300};
    pace_sender(1, 20, 6);
    queue_random(215);
    foreach (lead_plan[i]) begin
      write_min_lead(lead_plan[i]);
      pace_sender($urandom_range(1, 4), $urandom_range(4, 30), $urandom_range(0, 8));
      queue_random(215);
    end

    // far target: hold the compare disarmed, then pull the target behind now
    write_min_lead(16'd40);
    pace_sender(1, 12, 5);
    queue_op(FUNC_SET, plan_now + 64'd65600);
    queue_random(12);
    queue_op(FUNC_SET, plan_now - 64'd7);
    queue_op(FUNC_CANCEL, '0);

    write_min_lead(16'd0);
    queue_op(FUNC_SET, plan_now);
    queue_random(12);

    wait_settled();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_views.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", expected_views.size()));

    $display("Covered %0d transfers: %0d alarm sets, %0d cancels, %0d fires, %0d wraps,",
             results_seen, sets_done, cancels_done, fires_seen, wraps_done);
    $display("over %0d min_lead writes including 0 and 65535, with a long output stall.",
             leads_used);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: extended_timer_alarm_top.f
rtl/core/eta_pkg.sv
rtl/core/eta_if.sv
rtl/core/eta_arm.sv
rtl/core/extended_timer_alarm_top.sv
bench/tb.sv
